### design/longest_prefix_route_lookup_unit_defines.svh
// Assertion macros shared by the route lookup unit.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH

// The property must hold at every clock edge.
`define LPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// If ante holds, cons must hold in the same cycle.
`define LPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// If ante holds, cons must hold in the next cycle.
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

  // Table size and port width.
  localparam int unsigned Routes   = 64;
  localparam int unsigned PortBits = 4;
  localparam int unsigned AddrBits = 32;
  localparam int unsigned LenBits  = 6;

  // Longest meaningful prefix length.
  localparam logic [LenBits-1:0] MaxLen = LenBits'(AddrBits);

  typedef enum logic {
    CmdLookup = 1'b0,
    CmdInsert = 1'b1
  } lpr_cmd_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoRoute = 2'd1,
    StatusFull    = 2'd2
  } lpr_status_e;

  // Input word.
  typedef struct packed {
    lpr_cmd_e              command;
    logic [AddrBits-1:0]   address;
    logic [LenBits-1:0]    prefix_len;
    logic [AddrBits-1:0]   hop_in;
    logic [PortBits-1:0]   port_in;
  } lpr_in_t;

  // Output word.
  typedef struct packed {
    lpr_status_e           status;
    logic [AddrBits-1:0]   hop_out;
    logic [PortBits-1:0]   port_out;
    logic [LenBits-1:0]    match_len;
  } lpr_out_t;

  // Token that walks down the row of cells, one cell per cycle while the row is not halted.
  typedef struct packed {
    logic                  vld;
    lpr_cmd_e              cmd;
    logic [AddrBits-1:0]   addr;
    logic [LenBits-1:0]    len;
    logic [AddrBits-1:0]   hop;
    logic [PortBits-1:0]   port;
    logic                  done;
    logic [LenBits-1:0]    best_len;
    logic [AddrBits-1:0]   best_hop;
    logic [PortBits-1:0]   best_port;
  } lpr_tok_t;

  // Mask with len leading ones; len is at most 32.
  function automatic logic [AddrBits-1:0] lpr_len_mask(input logic [LenBits-1:0] len);
    lpr_len_mask = ~({AddrBits{1'b1}} >> len);
  endfunction

endpackage

`default_nettype wire

### design/lpr_cell.sv
`default_nettype none

module lpr_cell import lpr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     adv_i,
  input  wire lpr_tok_t tok_i,
  output lpr_tok_t      tok_o
);

  // Stored route of this slot.
  logic                e_vld_q;
  logic [AddrBits-1:0] e_pfx_q;
  logic [LenBits-1:0]  e_len_q;
  logic [AddrBits-1:0] e_hop_q;
  logic [PortBits-1:0] e_port_q;

  logic                tok_vld_q;
  lpr_tok_t            tok_q;
  lpr_tok_t            tok_d;

  logic                hit_ins;
  logic                take_ins;
  logic                match_lu;
  logic                take_lu;

  // Slots fill in order, so the first free slot is the next one to use.
  assign hit_ins  = e_vld_q && (e_len_q == tok_i.len) && (e_pfx_q == tok_i.addr);
  assign take_ins = tok_i.vld && (tok_i.cmd == CmdInsert) && !tok_i.done &&
                    (hit_ins || !e_vld_q);

  // A lookup only replaces the best match with a strictly longer one.
  assign match_lu = e_vld_q && ((tok_i.addr & lpr_len_mask(e_len_q)) == e_pfx_q);
  assign take_lu  = tok_i.vld && (tok_i.cmd == CmdLookup) && match_lu &&
                    (!tok_i.done || (e_len_q > tok_i.best_len));

  // Update the passing token.
  always_comb begin
    tok_d = tok_i;
    if (take_ins) begin
      tok_d.done = 1'b1;
    end
    if (take_lu) begin
      tok_d.done      = 1'b1;
      tok_d.best_len  = e_len_q;
      tok_d.best_hop  = e_hop_q;
      tok_d.best_port = e_port_q;
    end
  end

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
      e_vld_q   <= 1'b0;
    end else if (adv_i) begin
      tok_vld_q <= tok_i.vld;
      if (take_ins) begin
        e_vld_q <= 1'b1;
      end
    end
  end

  // Token payload and route contents.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      if (take_ins) begin
        e_pfx_q  <= tok_i.addr;
        e_len_q  <= tok_i.len;
        e_hop_q  <= tok_i.hop;
        e_port_q <= tok_i.port;
      end
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

`default_nettype wire

### design/longest_prefix_route_lookup_unit.sv
`default_nettype none

// Route table of 64 IPv4 routes with longest-prefix-match lookup, built as a
// row of 64 cells that each hold one route. An accepted word is held in the
// entry register, then passes down the row one cell per cycle while the row
// is not halted, and lands in the output register. Only one item is in the
// row at a time, and the next word is accepted at the first edge after the
// previous result lands in the output register, so a new word is not taken
// until the last one is through. A stalled result halts the row once the
// next token reaches its end. An insert replaces a route of equal prefix and
// length, or takes the next free slot, or reports table full. A lookup
// returns the hop, port and length of the longest matching route, or
// no-route status. Route valid marks are cleared by reset; no clearing pass is needed.

`include "longest_prefix_route_lookup_unit_defines.svh"

module longest_prefix_route_lookup_unit import lpr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire lpr_in_t in_word_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output lpr_out_t     out_word_o
);

  logic                busy_q;
  logic                in_acc;
  logic                adv;
  logic                out_vld_q;
  lpr_out_t            out_q;
  lpr_out_t            res;
  logic                head_vld_q;
  lpr_tok_t            head_q;
  lpr_tok_t            head_d;
  lpr_tok_t            head_tok;
  lpr_tok_t            chain_tok [Routes+1];
  lpr_tok_t            tail;
  logic [Routes:0]     tok_vld;
  logic [LenBits-1:0]  len_sat;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign tail       = chain_tok[Routes];

  // The row halts only when a finished token meets a full, stalled output.
  assign adv = !(tail.vld && out_vld_q && out_stall_i);

  // Build the entry token; insert prefixes are masked to their length.
  always_comb begin
    len_sat = (in_word_i.prefix_len > MaxLen) ? MaxLen : in_word_i.prefix_len;
    head_d.vld       = 1'b1;
    head_d.cmd       = in_word_i.command;
    head_d.addr      = (in_word_i.command == CmdInsert) ?
                       (in_word_i.address & lpr_len_mask(len_sat)) : in_word_i.address;
    head_d.len       = len_sat;
    head_d.hop       = in_word_i.hop_in;
    head_d.port      = in_word_i.port_in;
    head_d.done      = 1'b0;
    head_d.best_len  = '0;
    head_d.best_hop  = '0;
    head_d.best_port = '0;
  end

  // Entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
    end else if (in_acc) begin
      head_vld_q <= 1'b1;
    end else if (adv) begin
      head_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      head_q <= head_d;
    end
  end

  always_comb begin
    head_tok     = head_q;
    head_tok.vld = head_vld_q;
  end

  // Row of route cells.
  assign chain_tok[0] = head_tok;

  for (genvar g = 0; g < Routes; g++) begin : g_cell
    lpr_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (chain_tok[g]),
      .tok_o (chain_tok[g+1])
    );
  end

  // Result of the token leaving the last cell.
  always_comb begin
    if (tail.cmd == CmdInsert) begin
      res.status = tail.done ? StatusOk : StatusFull;
    end else begin
      res.status = tail.done ? StatusOk : StatusNoRoute;
    end
    res.hop_out   = tail.best_hop;
    res.port_out  = tail.best_port;
    res.match_len = tail.best_len;
  end

  // Output register and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      if (adv && tail.vld) begin
        out_vld_q <= 1'b1;
        busy_q    <= 1'b0;
      end else begin
        if (out_vld_q && !out_stall_i) begin
          out_vld_q <= 1'b0;
        end
        if (in_acc) begin
          busy_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail.vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Valid flags along the row, for checking.
  always_comb begin
    for (int i = 0; i <= Routes; i++) begin
      tok_vld[i] = chain_tok[i].vld;
    end
  end

  `LPR_ASSERT(a_one_token, $onehot0(tok_vld), "more than one token in the cell row")
  `LPR_ASSERT_NEXT(a_busy_after_acc, in_acc, busy_q, "busy not set after an accepted word")
  `LPR_ASSERT_IMPL(a_token_when_busy, busy_q, $countones(tok_vld) == 1,
                   "busy without a token in the row")
  `LPR_ASSERT_IMPL(a_out_from_tail, $rose(out_vld_q), $past(tail.vld),
                   "result appeared without a finished token")

endmodule

`default_nettype wire

### bench/route_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the route lookup unit. It keeps its own copy of
// the route table, works out the answer to every accepted input word and
// compares each accepted output word with the oldest answer still waiting.
module route_table_checker import lpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  lpr_in_t  in_word_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  lpr_out_t out_word_i,
  output int       fail_count_o,
  output int       pending_o
);

  // Shadow copy of the route table.
  logic [AddrBits-1:0] route_prefix [Routes];
  logic [LenBits-1:0]  route_len    [Routes];
  logic [AddrBits-1:0] route_hop    [Routes];
  logic [PortBits-1:0] route_port   [Routes];
  bit                  route_valid  [Routes];
  int                  route_count;

  lpr_out_t answer_q [$];
  int       fail_count = 0;
  int       result_index = 0;

  // Leading-ones mask for a length that is already at most 32.
  function automatic logic [AddrBits-1:0] prefix_mask(input logic [LenBits-1:0] len);
    if (len == '0) begin
      return '0;
    end
    return ~({AddrBits{1'b1}} >> len);
  endfunction

  // Applies one word to the shadow table and returns the answer it earns.
  function automatic lpr_out_t route_answer(input lpr_in_t w);
    lpr_out_t            r;
    logic [LenBits-1:0]  len;
    logic [AddrBits-1:0] key;
    int                  slot;
    bit                  found;
    r = '0;
    r.status = StatusOk;
    len = (w.prefix_len > MaxLen) ? MaxLen : w.prefix_len;
    if (w.command == CmdInsert) begin
      // An equal prefix and length is replaced, else the next free slot is taken.
      key = w.address & prefix_mask(len);
      slot = -1;
      for (int i = 0; i < Routes; i++) begin
        if (slot < 0 && route_valid[i] && route_len[i] == len && route_prefix[i] == key) begin
          slot = i;
        end
      end
      if (slot < 0 && route_count < Routes) begin
        slot = route_count;
        route_count++;
      end
      if (slot >= 0) begin
        route_prefix[slot] = key;
        route_len[slot]    = len;
        route_hop[slot]    = w.hop_in;
        route_port[slot]   = w.port_in;
        route_valid[slot]  = 1'b1;
      end else begin
        r.status = StatusFull;
      end
    end else begin
      // The first route of the greatest matching length wins.
      found = 1'b0;
      for (int i = 0; i < Routes; i++) begin
        if (route_valid[i] && (w.address & prefix_mask(route_len[i])) == route_prefix[i] &&
            (!found || route_len[i] > r.match_len)) begin
          found       = 1'b1;
          r.match_len = route_len[i];
          r.hop_out   = route_hop[i];
          r.port_out  = route_port[i];
        end
      end
      if (!found) begin
        r.status = StatusNoRoute;
      end
    end
    return r;
  endfunction

  // Results are taken before the new word is predicted, so a result and a
  // word accepted in the same cycle keep their order.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lpr_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Routes; i++) begin
        route_valid[i] = 1'b0;
      end
      route_count = 0;
      answer_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("result %0d with no word outstanding: status %0d hop %h port %h len %0d",
                     result_index, out_word_i.status, out_word_i.hop_out,
                     out_word_i.port_out, out_word_i.match_len);
          end
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (out_word_i !== want) begin
            if (fail_count < 10) begin
              $display("result %0d: expected status %0d hop %h port %h len %0d",
                       result_index, want.status, want.hop_out, want.port_out,
                       want.match_len);
              $display("result %0d: got      status %0d hop %h port %h len %0d",
                       result_index, out_word_i.status, out_word_i.hop_out,
                       out_word_i.port_out, out_word_i.match_len);
            end
            fail_count++;
          end
        end
        result_index++;
      end
      if (in_valid_i && !in_stall_i) begin
        answer_q.push_back(route_answer(in_word_i));
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= answer_q.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

// Drives the route lookup unit with directed and random words, applies the
// stall pattern of each phase and reports the verdict from the checker.
module testbench;
  import lpr_pkg::*;

  localparam int RandomItems = 1380;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 80;
  localparam int HoldAt      = 1000;
  localparam int HoldCycles  = 500;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lpr_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lpr_out_t out_word;

  int fail_count;
  int pending;
  int items_sent = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 65;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  // Addresses that random prefixes and lookups cluster around, and the most
  // recent insert keys, so that nested prefixes and replacements come up often.
  logic [AddrBits-1:0] base_pool   [16];
  logic [AddrBits-1:0] recent_addr [8];
  logic [LenBits-1:0]  recent_len  [8];

  longest_prefix_route_lookup_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  route_table_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic lpr_in_t make_word(input lpr_cmd_e cmd, input logic [AddrBits-1:0] addr,
                                        input logic [LenBits-1:0] len,
                                        input logic [AddrBits-1:0] hop,
                                        input logic [PortBits-1:0] port);
    lpr_in_t w;
    w.command    = cmd;
    w.address    = addr;
    w.prefix_len = len;
    w.hop_in     = hop;
    w.port_in    = port;
    return w;
  endfunction

  // Random word: mostly lookups near the base addresses, some inserts, a
  // share of them reusing a recent key, and a few fully random words.
  function automatic lpr_in_t random_word();
    logic [2:0]          k;
    logic [AddrBits-1:0] addr;
    logic [LenBits-1:0]  len;
    k = 3'($urandom_range(7));
    if ($urandom_range(99) < 22) begin
      if ($urandom_range(99) < 30) begin
        len  = recent_len[k];
        addr = recent_addr[k] ^ ($urandom() >> len);
      end else begin
        if ($urandom_range(99) < 80) begin
          addr = base_pool[4'($urandom_range(15))] ^ ($urandom() >> $urandom_range(32));
        end else begin
          addr = $urandom();
        end
        if ($urandom_range(99) < 85) begin
          len = LenBits'($urandom_range(32));
        end else begin
          len = LenBits'($urandom_range(63, 33));
        end
        recent_addr[k] = addr;
        recent_len[k]  = len;
      end
      return make_word(CmdInsert, addr, len, $urandom(), PortBits'($urandom_range(15)));
    end
    if ($urandom_range(99) < 70) begin
      addr = base_pool[4'($urandom_range(15))] ^ ($urandom() >> $urandom_range(32));
    end else begin
      addr = $urandom();
    end
    return make_word(CmdLookup, addr, LenBits'($urandom_range(63)), $urandom(),
                     PortBits'($urandom_range(15)));
  endfunction

  // Offers one word, with random gaps ahead of it, and waits until it is taken.
  task automatic offer(input lpr_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
    if (items_sent == 470) begin
      send_idle_pct = 65;
      recv_idle_pct = 21;
    end else if (items_sent == 940) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Receiver stalls: random per phase, plus one long hold-off that lets the
  // unit fill up while words keep being offered.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && items_sent >= HoldAt) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IdleLimit) begin
      $display("[longest_prefix_route_lookup_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    base_pool[0] = '0;
    base_pool[1] = '1;
    for (int i = 2; i < 16; i++) begin
      base_pool[i] = $urandom();
    end
    for (int i = 0; i < 8; i++) begin
      recent_addr[i] = base_pool[i];
      recent_len[i]  = LenBits'($urandom_range(32));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lookups on an empty table find no route.
    offer(make_word(CmdLookup, 32'h0000_0000, 6'd0, '0, '0));
    offer(make_word(CmdLookup, 32'hFFFF_FFFF, 6'd63, '1, '1));
    // A default route matches everything; its prefix bits are cleared.
    offer(make_word(CmdInsert, 32'hDEAD_BEEF, 6'd0, 32'hFFFF_FFFF, 4'hF));
    offer(make_word(CmdLookup, 32'h1234_5678, 6'd0, '0, '0));
    // A length above 32 saturates and so replaces the host route.
    offer(make_word(CmdInsert, 32'hFFFF_FFFF, 6'd32, 32'h0000_0000, 4'h0));
    offer(make_word(CmdInsert, 32'hFFFF_FFFF, 6'd63, 32'h0000_0001, 4'h5));
    offer(make_word(CmdLookup, 32'hFFFF_FFFF, 6'd0, '0, '0));
    offer(make_word(CmdLookup, 32'hFFFF_FFFE, 6'd0, '0, '0));
    // Nested prefixes with stray low bits: the longest match wins.
    offer(make_word(CmdInsert, 32'h0A12_3456, 6'd8, 32'h0A00_0001, 4'h1));
    offer(make_word(CmdInsert, 32'h0A12_3456, 6'd16, 32'h0A12_0001, 4'h2));
    offer(make_word(CmdInsert, 32'h0A12_3456, 6'd24, 32'h0A12_3401, 4'h3));
    offer(make_word(CmdLookup, 32'h0A12_3456, 6'd0, '0, '0));
    offer(make_word(CmdLookup, 32'h0A12_FFFF, 6'd0, '0, '0));
    offer(make_word(CmdLookup, 32'h0AFF_FFFF, 6'd0, '0, '0));
    offer(make_word(CmdLookup, 32'h0B00_0000, 6'd0, '0, '0));
    // One-bit prefix and a host route reached through length 33.
    offer(make_word(CmdInsert, 32'hC000_0000, 6'd1, 32'h8000_0000, 4'h8));
    offer(make_word(CmdLookup, 32'h8000_0000, 6'd0, '0, '0));
    offer(make_word(CmdInsert, 32'h0000_0001, 6'd33, 32'hAAAA_5555, 4'hA));
    offer(make_word(CmdLookup, 32'h0000_0001, 6'd0, '0, '0));
    // Same /8 again with different stray bits replaces the stored route.
    offer(make_word(CmdInsert, 32'h0AFF_FFFF, 6'd8, 32'h5555_AAAA, 4'h7));
    offer(make_word(CmdLookup, 32'h0A99_9999, 6'd0, '0, '0));

    for (int n = 0; n < RandomItems; n++) begin
      offer(random_word());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[longest_prefix_route_lookup_unit] OK");
    end else begin
      $display("[longest_prefix_route_lookup_unit] ERROR");
    end
    $finish;
  end

endmodule

### longest_prefix_route_lookup_unit.f
+incdir+design
design/lpr_pkg.sv
design/lpr_cell.sv
design/longest_prefix_route_lookup_unit.sv
bench/route_table_checker.sv
bench/testbench.sv
